// ===== hw/rtl/csp_pkg.sv =====
// Shared types, constants, character helpers and the color name table.
package csp_pkg;

    localparam int TEXT_BYTES = 9;
    localparam int NAME_COUNT = 31;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [3:0] HEX6_LEN = 4'd7;
    localparam logic [3:0] HEX3_LEN = 4'd4;
    localparam logic [3:0] PEND_MAX = 4'hF;

    typedef logic [0:TEXT_BYTES-1][7:0] t_text;

    typedef struct packed {
        logic       bad;
        logic [3:0] len;
        t_text      text;
    } t_snap;

    localparam t_text NAME_TEXT [NAME_COUNT] = '{
        {"red",       {6{8'h00}}},
        {"green",     {4{8'h00}}},
        {"blue",      {5{8'h00}}},
        {"black",     {4{8'h00}}},
        {"white",     {4{8'h00}}},
        {"yellow",    {3{8'h00}}},
        {"cyan",      {5{8'h00}}},
        {"magenta",   {2{8'h00}}},
        {"orange",    {3{8'h00}}},
        {"purple",    {3{8'h00}}},
        {"pink",      {5{8'h00}}},
        {"brown",     {4{8'h00}}},
        {"lime",      {5{8'h00}}},
        {"indigo",    {3{8'h00}}},
        {"violet",    {3{8'h00}}},
        {"gold",      {5{8'h00}}},
        {"silver",    {3{8'h00}}},
        {"gray",      {5{8'h00}}},
        {"grey",      {5{8'h00}}},
        {"navy",      {5{8'h00}}},
        {"teal",      {5{8'h00}}},
        {"olive",     {4{8'h00}}},
        {"maroon",    {3{8'h00}}},
        {"aqua",      {5{8'h00}}},
        {"beige",     {4{8'h00}}},
        {"coral",     {4{8'h00}}},
        {"chocolate"},
        {"khaki",     {4{8'h00}}},
        {"salmon",    {3{8'h00}}},
        {"orchid",    {3{8'h00}}},
        {"turquoise"}
    };

    localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
        4'd3, 4'd5, 4'd4, 4'd5, 4'd5, 4'd6, 4'd4, 4'd7, 4'd6, 4'd6, 4'd4,
        4'd5, 4'd4, 4'd6, 4'd6, 4'd4, 4'd6, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5,
        4'd6, 4'd4, 4'd5, 4'd5, 4'd9, 4'd5, 4'd6, 4'd6, 4'd9
    };

    localparam logic [23:0] NAME_COLOR [NAME_COUNT] = '{
        24'hFF0000, 24'h008000, 24'h0000FF, 24'h000000, 24'hFFFFFF, 24'hFFFF00,
        24'h00FFFF, 24'hFF00FF, 24'hFFA500, 24'h800080, 24'hFFC0CB, 24'hA52A2A,
        24'h00FF00, 24'h4B0082, 24'hEE82EE, 24'hFFD700, 24'hC0C0C0, 24'h808080,
        24'h808080, 24'h000080, 24'h008080, 24'h808000, 24'h800000, 24'h00FFFF,
        24'hF5F5DC, 24'hFF7F50, 24'hD2691E, 24'hF0E68C, 24'hFA8072, 24'hDA70D6,
        24'h40E0D0
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    endfunction

    // {is digit, digit value}
    function automatic logic [4:0] hex_dig(input logic [7:0] c);
        logic [4:0] d;
        begin
            d = 5'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = {1'b1, c[3:0]};
            end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
                d = {1'b1, c[3:0] + 4'd9};
            end
            return d;
        end
    endfunction

endpackage

// ===== hw/rtl/csp_if.sv =====
// Valid/ready channel interfaces for character input and color result.
interface csp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink (input valid, input char_code, input is_last, output ready);
endinterface

interface csp_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [23:0] color;

    modport source (output valid, output valid_res, output color, input ready);
    modport sink (input valid, input valid_res, input color, output ready);
endinterface

// ===== hw/rtl/color_spec_text_parser.sv =====
// Top level of the color text parser: collector stage followed by evaluator stage.
// Throughput: one character word per cycle unless a waiting snapshot stalls the input,
// with texts back to back and no gap. The last accepted word closes the text into the
// snapshot register; the evaluator then decodes it into the result register, where the
// result word waits; it and any pending snapshot hold until the result is taken.
// Reset (synchronous, active low) clears length, held spaces, overflow flag and both
// stage valids; the text buffer is not cleared and is only read below the length.
module color_spec_text_parser #(
    parameter int MAX_CONTENT = 9
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    csp_in_if.sink    i_in,
    csp_out_if.source o_out
);

    logic           snap_valid;
    logic           snap_ready;
    csp_pkg::t_snap snap;

    csp_collect #(
        .MAX_CONTENT (MAX_CONTENT)
    ) u_collect (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_snap_ready (snap_ready),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    csp_eval u_eval (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .o_snap_ready (snap_ready),
        .o_out        (o_out)
    );

endmodule

// ===== hw/rtl/csp_collect.sv =====
// Character collector: trims whitespace, fills the text buffer, snapshots on the last word.
module csp_collect #(
    parameter int MAX_CONTENT = 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    csp_in_if.sink         i_in,
    input  logic           i_snap_ready,
    output logic           o_snap_valid,
    output csp_pkg::t_snap o_snap
);

    localparam int LW = $clog2(MAX_CONTENT + 1);
    localparam int SW = $clog2(MAX_CONTENT + 17);

    logic [LW-1:0]  r_len, n_len;
    logic [3:0]     r_pend, n_pend;
    logic           r_too_long, n_too_long;
    logic [7:0]     r_buf [MAX_CONTENT];
    logic [7:0]     n_buf [MAX_CONTENT];
    logic           r_snap_valid;
    csp_pkg::t_snap r_snap, n_snap;

    logic          acc;
    logic          ws;
    logic [SW-1:0] base;
    logic [SW-1:0] fill_end;
    logic [SW-1:0] need;

    assign i_in.ready   = !r_snap_valid || i_snap_ready;
    assign acc          = i_in.valid && i_in.ready;
    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    always_comb begin
        ws         = csp_pkg::is_ws(i_in.char_code);
        base       = SW'(r_len);
        fill_end   = base + SW'(r_pend);
        need       = fill_end + SW'(1);
        n_len      = r_len;
        n_pend     = r_pend;
        n_too_long = r_too_long;
        n_buf      = r_buf;
        if (acc) begin
            if (ws) begin
                if (r_len != '0 && r_pend != csp_pkg::PEND_MAX) begin
                    n_pend = r_pend + 4'd1;
                end
            end else if (!r_too_long) begin
                if (need > SW'(MAX_CONTENT)) begin
                    n_too_long = 1'b1;
                end else begin
                    // flush held spaces, then append the word
                    for (int i = 0; i < MAX_CONTENT; i++) begin
                        if (SW'(i) >= base && SW'(i) < fill_end) begin
                            n_buf[i] = csp_pkg::CH_SPACE;
                        end else if (SW'(i) == fill_end) begin
                            n_buf[i] = i_in.char_code;
                        end
                    end
                    n_len  = need[LW-1:0];
                    n_pend = 4'd0;
                end
            end
        end
    end

    always_comb begin
        n_snap.bad = n_too_long || (n_len == '0) || (n_len > LW'(csp_pkg::TEXT_BYTES));
        n_snap.len = n_snap.bad ? 4'd0 : n_len[3:0];
        for (int i = 0; i < csp_pkg::TEXT_BYTES; i++) begin
            n_snap.text[i] = n_buf[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_pend       <= 4'd0;
            r_too_long   <= 1'b0;
            r_snap_valid <= 1'b0;
        end else if (acc && i_in.is_last) begin
            r_len        <= '0;
            r_pend       <= 4'd0;
            r_too_long   <= 1'b0;
            r_snap_valid <= 1'b1;
        end else begin
            r_len      <= n_len;
            r_pend     <= n_pend;
            r_too_long <= n_too_long;
            if (i_snap_ready) begin
                r_snap_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (acc && i_in.is_last) begin
            r_snap <= n_snap;
        end
    end

endmodule

// ===== hw/rtl/csp_eval.sv =====
// Evaluator: decodes hex forms and color names from the snapshot into the result register.
module csp_eval (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_snap_valid,
    input  csp_pkg::t_snap i_snap,
    output logic           o_snap_ready,
    csp_out_if.source      o_out
);

    logic        r_out_valid;
    logic        r_valid_res, n_valid_res;
    logic [23:0] r_color, n_color;

    csp_pkg::t_text lc;
    logic           name_ok;
    logic [23:0]    name_color;

    function automatic logic [7:0] field2(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] ha;
        logic [4:0] hb;
        logic [7:0] v;
        logic       neg;
        begin
            ha  = csp_pkg::hex_dig(a);
            hb  = csp_pkg::hex_dig(b);
            v   = 8'h00;
            neg = 1'b0;
            if (csp_pkg::is_ws(a)) begin
                if (hb[4]) v = {4'h0, hb[3:0]};
            end else if (a == csp_pkg::CH_PLUS || a == csp_pkg::CH_MINUS) begin
                neg = (a == csp_pkg::CH_MINUS);
                if (hb[4]) v = {4'h0, hb[3:0]};
            end else if (ha[4]) begin
                v = hb[4] ? {ha[3:0], hb[3:0]} : {4'h0, ha[3:0]};
            end
            if (neg) v = 8'h00 - v;
            return v;
        end
    endfunction

    function automatic logic [7:0] field1(input logic [7:0] a);
        logic [4:0] ha;
        begin
            ha = csp_pkg::hex_dig(a);
            return ha[4] ? {ha[3:0], ha[3:0]} : 8'h00;
        end
    endfunction

    assign o_snap_ready = !r_out_valid || o_out.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.valid_res = r_valid_res;
    assign o_out.color     = r_color;

    always_comb begin
        for (int i = 0; i < csp_pkg::TEXT_BYTES; i++) begin
            lc[i] = (4'(i) < i_snap.len) ? csp_pkg::to_lower(i_snap.text[i]) : 8'h00;
        end
        name_ok    = 1'b0;
        name_color = 24'h000000;
        for (int k = 0; k < csp_pkg::NAME_COUNT; k++) begin
            if (lc == csp_pkg::NAME_TEXT[k] && i_snap.len == csp_pkg::NAME_LEN[k]) begin
                name_ok    = 1'b1;
                name_color = name_color | csp_pkg::NAME_COLOR[k];
            end
        end
    end

    always_comb begin
        n_valid_res = 1'b0;
        n_color     = 24'h000000;
        if (!i_snap.bad) begin
            if (i_snap.text[0] == csp_pkg::CH_HASH) begin
                if (i_snap.len == csp_pkg::HEX6_LEN) begin
                    n_valid_res = 1'b1;
                    n_color     = {field2(i_snap.text[1], i_snap.text[2]),
                                   field2(i_snap.text[3], i_snap.text[4]),
                                   field2(i_snap.text[5], i_snap.text[6])};
                end else if (i_snap.len == csp_pkg::HEX3_LEN) begin
                    n_valid_res = 1'b1;
                    n_color     = {field1(i_snap.text[1]), field1(i_snap.text[2]),
                                   field1(i_snap.text[3])};
                end
            end else begin
                n_valid_res = name_ok;
                n_color     = name_color;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_snap_valid && o_snap_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap_valid && o_snap_ready) begin
            r_valid_res <= n_valid_res;
            r_color     <= n_color;
        end
    end

endmodule

// ===== hw/rtl/csp_checker.sv =====
// Port-level assertions for the color text parser and their bind to the top level.
module csp_assertions (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_is_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_valid_res,
    input logic [23:0] i_out_color
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word present after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_color) && $stable(i_out_valid_res))
        else $error("stalled result word changed");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_valid_res |-> i_out_color == 24'h000000)
        else $error("invalid result carries a nonzero color");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_is_last && !i_out_valid |=> ##1 i_out_valid)
        else $error("no result word two cycles after the last word");

endmodule

bind color_spec_text_parser csp_assertions u_csp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_is_last    (i_in.is_last),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_valid_res (o_out.valid_res),
    .i_out_color     (o_out.color)
);

// ===== bench/csp_checker.sv =====
`timescale 1ns / 100ps
// Color text checker: follows accepted words, predicts each result and compares it.
module csp_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    csp_in_if    i_in,
    csp_out_if   i_out,
    output int   o_fail_count,
    output int   o_waiting,
    output int   o_good_count,
    output int   o_bad_count
);

    typedef struct packed {
        logic        ok;
        logic [23:0] rgb;
    } color_result_t;

    localparam int NAME_TOTAL = 31;
    localparam int NAME_BITS  = 8 * csp_pkg::TEXT_BYTES;

    localparam logic [NAME_BITS-1:0] COLOR_NAMES [NAME_TOTAL] = '{
        "red", "green", "blue", "black", "white", "yellow", "cyan", "magenta",
        "orange", "purple", "pink", "brown", "lime", "indigo", "violet", "gold",
        "silver", "gray", "grey", "navy", "teal", "olive", "maroon", "aqua",
        "beige", "coral", "chocolate", "khaki", "salmon", "orchid", "turquoise"
    };

    localparam logic [23:0] COLOR_VALUES [NAME_TOTAL] = '{
        24'hFF0000, 24'h008000, 24'h0000FF, 24'h000000, 24'hFFFFFF, 24'hFFFF00,
        24'h00FFFF, 24'hFF00FF, 24'hFFA500, 24'h800080, 24'hFFC0CB, 24'hA52A2A,
        24'h00FF00, 24'h4B0082, 24'hEE82EE, 24'hFFD700, 24'hC0C0C0, 24'h808080,
        24'h808080, 24'h000080, 24'h008080, 24'h808000, 24'h800000, 24'h00FFFF,
        24'hF5F5DC, 24'hFF7F50, 24'hD2691E, 24'hF0E68C, 24'hFA8072, 24'hDA70D6,
        24'h40E0D0
    };

    logic [7:0]    text_buf [csp_pkg::TEXT_BYTES];
    int            text_len;
    int            held_spaces;
    logic          overflow;
    color_result_t expected_colors [$];
    int            fails;
    int            good;
    int            bad;

    function automatic logic blank_char(input logic [7:0] c);
        return (c == csp_pkg::CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] field_value(input int start, input int n);
        int         i;
        logic [7:0] v;
        logic       neg;
        i = 0;
        v = '0;
        neg = 1'b0;
        while (i < n && blank_char(text_buf[start + i])) i++;
        if (i < n && (text_buf[start + i] == csp_pkg::CH_PLUS ||
                      text_buf[start + i] == csp_pkg::CH_MINUS)) begin
            neg = text_buf[start + i] == csp_pkg::CH_MINUS;
            i++;
        end
        if (i + 2 < n && text_buf[start + i] == 8'h30 &&
            fold_case(text_buf[start + i + 1]) == 8'h78 &&
            hex_digit_value(text_buf[start + i + 2]) >= 0) begin
            i += 2;
        end
        while (i < n && hex_digit_value(text_buf[start + i]) >= 0) begin
            v = {v[3:0], 4'(hex_digit_value(text_buf[start + i]))};
            i++;
        end
        if (neg) v = -v;
        return v;
    endfunction

    function automatic color_result_t evaluate_text();
        color_result_t r;
        logic [7:0]    red;
        logic [7:0]    grn;
        logic [7:0]    blu;
        int            name_len;
        logic          hit;
        r = '0;
        if (overflow || text_len == 0) return r;
        if (text_buf[0] == csp_pkg::CH_HASH) begin
            if (text_len == csp_pkg::HEX6_LEN) begin
                r.ok  = 1'b1;
                r.rgb = {field_value(1, 2), field_value(3, 2), field_value(5, 2)};
            end else if (text_len == csp_pkg::HEX3_LEN) begin
                red   = field_value(1, 1) * 8'd17;
                grn   = field_value(2, 1) * 8'd17;
                blu   = field_value(3, 1) * 8'd17;
                r.ok  = 1'b1;
                r.rgb = {red, grn, blu};
            end
            return r;
        end
        for (int k = 0; k < NAME_TOTAL; k++) begin
            name_len = 0;
            for (int b = 0; b < csp_pkg::TEXT_BYTES; b++) begin
                if (COLOR_NAMES[k][b*8 +: 8] != 8'h00) name_len = b + 1;
            end
            if (name_len == text_len) begin
                hit = 1'b1;
                for (int i = 0; i < name_len; i++) begin
                    if (fold_case(text_buf[i]) != COLOR_NAMES[k][(name_len-1-i)*8 +: 8]) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    r.ok  = 1'b1;
                    r.rgb = COLOR_VALUES[k];
                    return r;
                end
            end
        end
        return r;
    endfunction

    task automatic take_word(input logic [7:0] c, input logic last);
        if (blank_char(c)) begin
            if (text_len != 0 && held_spaces < csp_pkg::PEND_MAX) held_spaces++;
        end else if (!overflow) begin
            if (text_len + held_spaces + 1 > csp_pkg::TEXT_BYTES) begin
                overflow = 1'b1;
            end else begin
                while (held_spaces != 0) begin
                    text_buf[text_len] = csp_pkg::CH_SPACE;
                    text_len++;
                    held_spaces--;
                end
                text_buf[text_len] = c;
                text_len++;
            end
        end
        if (last) begin
            expected_colors.push_back(evaluate_text());
            text_len = 0;
            held_spaces = 0;
            overflow = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        color_result_t want;
        if (!i_rst_n) begin
            text_len = 0;
            held_spaces = 0;
            overflow = 1'b0;
            expected_colors.delete();
            fails = 0;
            good = 0;
            bad = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_colors.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual valid_res %0b color %06h",
                             $time, i_out.valid_res, i_out.color);
                end else begin
                    want = expected_colors.pop_front();
                    if (i_out.valid_res !== want.ok) begin
                        fails++;
                        $display("%0t: valid_res mismatch, expected %0b, actual %0b",
                                 $time, want.ok, i_out.valid_res);
                    end
                    if (i_out.color !== want.rgb) begin
                        fails++;
                        $display("%0t: color mismatch, expected %06h, actual %06h",
                                 $time, want.rgb, i_out.color);
                    end
                    if (want.ok) good++;
                    else bad++;
                end
            end
            if (i_in.valid && i_in.ready) take_word(i_in.char_code, i_in.is_last);
        end
        o_fail_count <= fails;
        o_waiting    <= expected_colors.size();
        o_good_count <= good;
        o_bad_count  <= bad;
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Bench top for the color text parser: clock, reset, text stimulus, stalls and verdict.
module testbench;

    localparam int ITEM_TARGET  = 1850;
    localparam int CALM_WORDS   = 250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    csp_in_if  in_ch ();
    csp_out_if out_ch ();

    int         fail_count;
    int         waiting;
    int         good_count;
    int         bad_count;
    int         cycles = 0;
    int         words_sent = 0;
    int         texts_sent = 0;
    int         name_turn = 0;
    logic       calm = 1'b0;
    logic       gaps_on = 1'b1;
    logic [7:0] text_q [$];

    color_spec_text_parser u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    csp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_good_count (good_count),
        .o_bad_count  (bad_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int stall;
        int quiet_left;
        stall = 0;
        quiet_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (quiet_left > 0) begin
                quiet_left--;
            end else if ($urandom_range(0, 99) == 0) begin
                quiet_left = $urandom_range(20, 80);
            end
            if (stall == 0 && !calm && quiet_left == 0 && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 10);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic [7:0] c, input logic last);
        int gap;
        gap = 0;
        if (!calm && gaps_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 10);
        if (gap > 0) begin
            in_ch.valid     <= 1'b0;
            in_ch.char_code <= 8'($urandom);
            in_ch.is_last   <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.char_code <= c;
        in_ch.is_last   <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic send_text();
        gaps_on = $urandom_range(0, 3) != 0;
        foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
        texts_sent++;
        text_q.delete();
    endtask

    // hold off until every pending result has come back
    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
    endtask

    task automatic push_string(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] blank_byte();
        int n;
        n = $urandom_range(0, 5);
        return (n == 0) ? csp_pkg::CH_SPACE : 8'(8'h09 + n - 1);
    endfunction

    task automatic push_blanks(input int n);
        repeat (n) text_q.push_back(blank_byte());
    endtask

    function automatic logic [7:0] hex_char();
        int n;
        n = $urandom_range(0, 21);
        if (n < 10) return 8'(8'h30 + n);
        if (n < 16) return 8'(8'h61 + n - 10);
        return 8'(8'h41 + n - 16);
    endfunction

    function automatic logic [7:0] field_char();
        case ($urandom_range(0, 15))
            0:       return csp_pkg::CH_MINUS;
            1:       return csp_pkg::CH_PLUS;
            2:       return csp_pkg::CH_SPACE;
            3:       return 8'h78;
            4:       return 8'h00;
            5:       return 8'($urandom);
            default: return hex_char();
        endcase
    endfunction

    task automatic push_name(input int k);
        logic [7:0] c;
        for (int i = 0; i < csp_pkg::NAME_LEN[k]; i++) begin
            c = csp_pkg::NAME_TEXT[k][i];
            if ($urandom_range(0, 2) == 0) c = c ^ 8'h20;
            text_q.push_back(c);
        end
    endtask

    task automatic build_random_text();
        int pick;
        int k;
        int n;
        int start;
        pick = $urandom_range(0, 99);
        push_blanks($urandom_range(0, 2));
        start = text_q.size();
        if (name_turn < csp_pkg::NAME_COUNT) k = name_turn;
        else k = $urandom_range(0, csp_pkg::NAME_COUNT - 1);
        if (pick < 25) begin
            text_q.push_back(csp_pkg::CH_HASH);
            repeat (6) text_q.push_back(field_char());
        end else if (pick < 40) begin
            text_q.push_back(csp_pkg::CH_HASH);
            repeat (3) text_q.push_back(field_char());
        end else if (pick < 65) begin
            push_name(k);
            name_turn++;
        end else if (pick < 77) begin
            push_name(k);
            case ($urandom_range(0, 4))
                0: void'(text_q.pop_back());
                1: text_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
                2: text_q[start + $urandom_range(0, csp_pkg::NAME_LEN[k] - 1)] = 8'($urandom);
                3: text_q.insert(start + $urandom_range(1, csp_pkg::NAME_LEN[k] - 1),
                                 csp_pkg::CH_SPACE);
                default: begin
                    text_q = text_q[0:start-1];
                    text_q.push_back(csp_pkg::CH_HASH);
                    case ($urandom_range(0, 5))
                        0:       n = 0;
                        1:       n = 1;
                        2:       n = 2;
                        3:       n = 4;
                        4:       n = 5;
                        default: n = 7;
                    endcase
                    repeat (n) text_q.push_back(hex_char());
                end
            endcase
        end else if (pick < 87) begin
            case ($urandom_range(0, 2))
                0: repeat ($urandom_range(10, 14)) text_q.push_back(hex_char());
                1: begin
                    push_name(k);
                    push_blanks($urandom_range(15, 20));
                    text_q.push_back(hex_char());
                end
                default: begin
                    push_name(k);
                    push_blanks($urandom_range(15, 24));
                end
            endcase
        end else if (pick < 95) begin
            repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom));
        end else begin
            push_blanks($urandom_range(1, 3));
        end
        push_blanks($urandom_range(0, 2));
        if (text_q.size() == 0) text_q.push_back(blank_byte());
    endtask

    initial begin
        logic paused_mid;
        paused_mid = 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.char_code <= 8'h00;
        in_ch.is_last   <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        text_q.push_back(8'h0A);
        send_text();
        push_string("#-F");
        text_q.push_back(8'h00);
        push_string("Fa9");
        send_text();
        text_q.push_back(8'h09);
        push_string("GrEy");
        text_q.push_back(8'h0D);
        send_text();
        push_string("#fA0");
        send_text();
        push_string("a b");
        send_text();
        text_q.push_back(8'hFF);
        send_text();
        push_string("TURQUOISE");
        send_text();
        pause_until_drained();

        while (words_sent < ITEM_TARGET) begin
            if (!paused_mid && words_sent >= ITEM_TARGET / 2) begin
                pause_until_drained();
                paused_mid = 1'b1;
            end
            if (words_sent >= ITEM_TARGET - CALM_WORDS) calm = 1'b1;
            build_random_text();
            send_text();
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        $display("sent %0d texts in %0d words: %0d gave a color, %0d were rejected",
                 texts_sent, words_sent, good_count, bad_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/csp_pkg.sv
hw/rtl/csp_if.sv
hw/rtl/csp_collect.sv
hw/rtl/csp_eval.sv
hw/rtl/color_spec_text_parser.sv
hw/rtl/csp_checker.sv
bench/csp_checker.sv
bench/testbench.sv
